### src/swec_pkg.sv
// Shared types and fixed field widths for the sliding window entry cache.
// No dependencies; imported by sliding_window_entry_cache.
`timescale 1ns / 1ps
`default_nettype none

package swec_pkg;

    // Fixed widths of the transaction fields.
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 16;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;

    // The shift remainder takes a reciprocal multiply step and a correction step.
    localparam int MOD_STEPS = 2;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_SHIFT      = 3'd0,
        MODE_READ       = 3'd1,
        MODE_FILL       = 3'd2,
        MODE_IS_LOADED  = 3'd3,
        MODE_COUNT_DOWN = 3'd4,
        MODE_COUNT_UP   = 3'd5
    } mode_t;

endpackage

`default_nettype wire

### src/sliding_window_entry_cache.sv
// Sliding window entry cache: ring of SLOTS entries around a 16-bit center index.
// Depends on swec_pkg for field widths and operation codes.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block:
// The input channel (in_valid/in_ready) carries one operation per transaction:
// mode, index, write_data and limit. The output channel (out_valid/out_ready)
// returns exactly one result per operation: hit, read_data and loaded_count.
// Operations are handled one at a time. Each is latched and decoded; fill,
//   is_loaded, a read miss, unused modes and a shift to the current center
//   then go straight to the result stage. A read hit first reads the entry
//   memory. Any other shift first passes the remainder unit that reduces
//   the shift distance modulo SLOTS with a reciprocal multiply and a
//   correction step, then moves the center. count_down / count_up first
//   walk the loaded flags, testing one loaded flag per cycle, and pass at
//   most SLOTS/2 of them before the walk stops.
// The next transaction can be accepted from the cycle after the result is loaded.
// Entry data sits in a synchronous memory with registered read data;
// loaded flags are flip-flops.
// Reset clears the center, the ring position and all loaded flags; entry
// data is not cleared and is only returned for slots loaded by a fill.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls with a result still held, the next
// result waits inside the block until the output register frees up.
module sliding_window_entry_cache #(
    parameter int SLOTS  = 16,
    parameter int DATA_W = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [swec_pkg::MODE_W-1:0]   mode,
    input  wire logic [swec_pkg::INDEX_W-1:0]  index,
    input  wire logic [swec_pkg::WORD_W-1:0]   write_data,
    input  wire logic [swec_pkg::INDEX_W-1:0]  limit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [swec_pkg::WORD_W-1:0]        read_data,
    output logic [swec_pkg::COUNT_W-1:0]       loaded_count
);

    import swec_pkg::*;

    localparam int HALF  = SLOTS / 2;
    localparam int SW    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int SWP   = SW + 1;
    localparam int KW    = $clog2(HALF + 1) > 0 ? $clog2(HALF + 1) : 1;
    localparam int MCW   = $clog2(MOD_STEPS);
    localparam int WALKW = INDEX_W + 1;
    localparam int PRODW = INDEX_W + WORD_W;

    localparam logic [SWP-1:0]     SLOTS_X   = SWP'(SLOTS);
    localparam logic [INDEX_W-1:0] SLOTS_I   = INDEX_W'(SLOTS);
    localparam logic [SW-1:0]      HALF_S    = SW'(HALF);
    localparam logic [SW-1:0]      ONE_S     = SW'(1);
    localparam logic [INDEX_W-1:0] HALF_I    = INDEX_W'(HALF);
    localparam logic [KW-1:0]      HALF_K    = KW'(HALF);
    localparam logic [MCW-1:0]     MOD_LAST  = MCW'(MOD_STEPS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    // Floor of 2^32 / SLOTS; the quotient it yields is low by at most one.
    localparam logic [WORD_W-1:0]  RECIP     = WORD_W'(64'h1_0000_0000 / 64'(SLOTS));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_SHIFT,
        S_READ,
        S_COUNT,
        S_RESULT
    } state_t;

    // Ring arithmetic on slot numbers below SLOTS.
    function automatic logic [SW-1:0] add_wrap(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SWP-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SLOTS_X)
            s = s - SLOTS_X;
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] sub_wrap(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SWP-1:0] s;
        if (a >= b)
            s = {1'b0, a} - {1'b0, b};
        else
            s = {1'b0, a} + SLOTS_X - {1'b0, b};
        return s[SW-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [KW-1:0] k);
        logic [KW+COUNT_W-1:0] kx;
        kx = {{COUNT_W{1'b0}}, k};
        if (kx > {{KW{1'b0}}, COUNT_MAX})
            return COUNT_MAX;
        return kx[COUNT_W-1:0];
    endfunction

    state_t               state_reg;
    mode_t                op_mode_reg;
    logic [INDEX_W-1:0]   op_index_reg;
    logic [WORD_W-1:0]    op_wdata_reg;
    logic [INDEX_W-1:0]   op_limit_reg;

    logic [INDEX_W-1:0]   center_index_reg;
    logic [SW-1:0]        center_slot_reg;
    logic [SLOTS-1:0]     loaded_reg;

    logic [INDEX_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [SW-1:0]        rem_reg;
    logic [MCW-1:0]       mod_cnt_reg;
    logic [INDEX_W-1:0]   quot_reg;

    logic [KW-1:0]        walk_k_reg;
    logic [SW-1:0]        walk_slot_reg;
    logic [WALKW-1:0]     walk_idx_reg;

    logic                 res_hit_reg;
    logic [WORD_W-1:0]    res_data_reg;
    logic [COUNT_W-1:0]   res_cnt_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [WORD_W-1:0]    read_data_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [DATA_W-1:0]    entry_mem [SLOTS];
    logic [DATA_W-1:0]    mem_rdata_reg;

    // Window lookup of the latched index against the current center.
    logic [INDEX_W-1:0]   diff;
    logic [INDEX_W-1:0]   diff_neg;
    logic                 win_pos;
    logic                 win_neg;
    logic                 in_win;
    logic [SW-1:0]        target_slot;
    logic                 target_loaded;

    assign diff          = op_index_reg - center_index_reg;
    assign diff_neg      = INDEX_W'(0) - diff;
    assign win_pos       = !diff[INDEX_W-1] && (diff < HALF_I);
    assign win_neg       = diff[INDEX_W-1] && (diff_neg < HALF_I);
    assign in_win        = win_pos || win_neg;
    assign target_slot   = win_pos ? add_wrap(center_slot_reg, diff[SW-1:0])
                                   : sub_wrap(center_slot_reg, diff_neg[SW-1:0]);
    assign target_loaded = loaded_reg[target_slot];

    // Shift distance modulo SLOTS: reciprocal quotient, then one correction.
    logic [PRODW-1:0]     recip_prod;
    logic [INDEX_W-1:0]   recip_q;
    logic [INDEX_W-1:0]   rem_raw;
    logic [INDEX_W-1:0]   rem_fix;

    assign recip_prod = {{WORD_W{1'b0}}, mag_reg} * {{INDEX_W{1'b0}}, RECIP};
    assign recip_q    = recip_prod[PRODW-1:WORD_W];
    assign rem_raw    = mag_reg - quot_reg * SLOTS_I;
    assign rem_fix    = (rem_raw >= SLOTS_I) ? rem_raw - SLOTS_I : rem_raw;

    // Shift: new ring position and the flag slot that drops out of the window.
    logic [SW-1:0]        slot_next;
    logic [SW-1:0]        clear_slot;

    assign slot_next  = neg_reg ? sub_wrap(center_slot_reg, rem_reg)
                                : add_wrap(center_slot_reg, rem_reg);
    assign clear_slot = neg_reg ? add_wrap(slot_next, HALF_S)
                                : sub_wrap(slot_next, HALF_S);

    // Count walk: end conditions for the current step.
    logic                 walk_down;
    logic                 walk_bound;
    logic                 walk_flag;

    assign walk_down  = (op_mode_reg == MODE_COUNT_DOWN);
    assign walk_bound = walk_down ? (walk_idx_reg >= {1'b0, op_limit_reg})
                                  : walk_idx_reg[WALKW-1];
    assign walk_flag  = loaded_reg[walk_slot_reg];

    // Entry memory port control.
    logic                 mem_we;
    logic [SW-1:0]        mem_addr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [DATA_W+WORD_W-1:0] wdata_ext;
    logic [DATA_W+WORD_W-1:0] rdata_ext;

    assign wdata_ext = {{DATA_W{1'b0}}, op_wdata_reg};
    assign rdata_ext = {{WORD_W{1'b0}}, mem_rdata_reg};
    assign mem_wdata = wdata_ext[DATA_W-1:0];
    assign mem_addr  = target_slot;
    assign mem_we    = (state_reg == S_DECODE) && (op_mode_reg == MODE_FILL) && in_win;

    // The output register takes a new result when it is empty or being drained.
    logic                 load_out;

    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

    // Synchronous entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= entry_mem[mem_addr];
    end

    // Operation sequencer, cache state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            center_index_reg <= '0;
            center_slot_reg  <= '0;
            loaded_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_mode_reg  <= mode_t'(mode);
                        op_index_reg <= index;
                        op_wdata_reg <= write_data;
                        op_limit_reg <= limit;
                        state_reg    <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    res_hit_reg  <= 1'b0;
                    res_data_reg <= '0;
                    res_cnt_reg  <= '0;
                    state_reg    <= S_RESULT;
                    unique case (op_mode_reg)
                        MODE_SHIFT:
                        begin
                            if (diff != '0)
                            begin
                                mag_reg     <= diff[INDEX_W-1] ? diff_neg : diff;
                                neg_reg     <= diff[INDEX_W-1];
                                rem_reg     <= '0;
                                mod_cnt_reg <= '0;
                                state_reg   <= S_MOD;
                            end
                        end
                        MODE_READ:
                        begin
                            if (in_win && target_loaded)
                                state_reg <= S_READ;
                        end
                        MODE_FILL:
                        begin
                            if (in_win)
                            begin
                                loaded_reg[target_slot] <= 1'b1;
                                res_hit_reg             <= 1'b1;
                            end
                        end
                        MODE_IS_LOADED:
                        begin
                            res_hit_reg <= in_win && target_loaded;
                        end
                        MODE_COUNT_DOWN,
                        MODE_COUNT_UP:
                        begin
                            walk_k_reg    <= '0;
                            walk_slot_reg <= center_slot_reg;
                            walk_idx_reg  <= {1'b0, center_index_reg};
                            state_reg     <= S_COUNT;
                        end
                        default:
                        begin
                            res_hit_reg <= 1'b0;
                        end
                    endcase
                end

                // First the reciprocal quotient, then the corrected remainder.
                S_MOD:
                begin
                    mod_cnt_reg <= mod_cnt_reg + MCW'(1);
                    if (mod_cnt_reg == MOD_LAST)
                    begin
                        rem_reg   <= rem_fix[SW-1:0];
                        state_reg <= S_SHIFT;
                    end
                    else
                        quot_reg <= recip_q;
                end

                S_SHIFT:
                begin
                    center_index_reg       <= op_index_reg;
                    center_slot_reg        <= slot_next;
                    loaded_reg[clear_slot] <= 1'b0;
                    state_reg              <= S_RESULT;
                end

                S_READ:
                begin
                    res_hit_reg  <= 1'b1;
                    res_data_reg <= rdata_ext[WORD_W-1:0];
                    state_reg    <= S_RESULT;
                end

                // One flag per cycle, walking away from the center.
                S_COUNT:
                begin
                    if (walk_k_reg == HALF_K || walk_bound)
                    begin
                        res_cnt_reg <= sat_count(HALF_K);
                        state_reg   <= S_RESULT;
                    end
                    else if (!walk_flag)
                    begin
                        res_cnt_reg <= sat_count(walk_k_reg);
                        state_reg   <= S_RESULT;
                    end
                    else
                    begin
                        walk_k_reg    <= walk_k_reg + KW'(1);
                        walk_slot_reg <= walk_down ? add_wrap(walk_slot_reg, ONE_S)
                                                   : sub_wrap(walk_slot_reg, ONE_S);
                        walk_idx_reg  <= walk_down ? walk_idx_reg + WALKW'(1)
                                                   : walk_idx_reg - WALKW'(1);
                    end
                end

                // Hand the result to the output register once it is free.
                S_RESULT:
                begin
                    if (load_out)
                    begin
                        hit_reg       <= res_hit_reg;
                        read_data_reg <= res_data_reg;
                        count_reg     <= res_cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign read_data    = read_data_reg;
    assign loaded_count = count_reg;

endmodule

`default_nettype wire
